// ===== sv/bba_pkg.sv =====
// Shared constants, codes and types of the bitmap block allocator.
// Has no dependencies; bitmap_block_allocator_core imports it.
package bba_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int WORD_W     = (MAX_BLOCKS < 64) ? MAX_BLOCKS / 2 : 32;
  localparam int NUM_WORDS  = MAX_BLOCKS / WORD_W;
  localparam int BLK_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = BLK_W + 1;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int WADDR_W    = $clog2(NUM_WORDS);

  localparam int BS_W      = 13;
  localparam int COUNT_W   = 11;
  localparam int CFG_W     = 13;
  localparam int SIZE_W    = 23;
  localparam int IDX_W     = 10;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;
  localparam int DIVD_W    = SIZE_W + 1;
  localparam int SUM_W     = DIVD_W + 1;
  localparam int DIV_STEPS = DIVD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic              cfg_idx_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam action_t ACT_ALLOC   = 2'd0;
  localparam action_t ACT_RELEASE = 2'd1;
  localparam action_t ACT_RESIZE  = 2'd2;

  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_NONE_FREE = 2'd1;
  localparam status_t ST_COMPACT   = 2'd2;

  localparam cfg_idx_t CFG_BLK_BYTES     = 1'b0;
  localparam cfg_idx_t CFG_BLOCKS_IN_USE = 1'b1;

endpackage

// ===== sv/bitmap_block_allocator_core.sv =====
// Bitmap block allocator: used/free map in a word-wide memory, first-fit allocate,
// release and resize of block extents. Depends on bba_pkg.
//
// Usage:
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 bytes per block,
//   1 managed block count) at the clock edge; write only while no request is in flight.
//   Input channel: a request beat (action, start_block, old_size, new_size) is
//   taken when in_valid is high and in_stall is low. in_stall is high from the
//   accept until the result moves into the output register.
//   Output channel: one beat (status, block_index) per request, held in an output
//   register until out_valid is high and out_stall is low. The next request is
//   accepted while that beat still waits; its result then waits for the register.
//   Steps from accept to out_valid: the map is 32-bit words, each visited in a read
//   state and then a check or write state. Allocate scans words in order, up to 32
//   at 1024 blocks. Release runs the divider, then clears its words. Resize runs the
//   divider twice, then walks its words, and a growth that passes its check visits
//   its words twice. A new request is taken once back in idle after a result loads.
//   Reset: all blocks free (per-word valid bits clear), 64 bytes per block,
//   1024 managed blocks, no beat pending. No clearing pass is needed.
module bitmap_block_allocator_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  bba_pkg::cfg_idx_t           cfg_index,
  input  logic [bba_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bba_pkg::action_t            action,
  input  logic [bba_pkg::IDX_W-1:0]   start_block,
  input  logic [bba_pkg::SIZE_W-1:0]  old_size,
  input  logic [bba_pkg::SIZE_W-1:0]  new_size,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bba_pkg::status_t            status,
  output logic [bba_pkg::IDX_W-1:0]   block_index
);
  import bba_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_ALLOC_RD  = 8'b0000_0010,
    S_ALLOC_CHK = 8'b0000_0100,
    S_DIV       = 8'b0000_1000,
    S_SETUP     = 8'b0001_0000,
    S_RNG_RD    = 8'b0010_0000,
    S_RNG_WR    = 8'b0100_0000,
    S_DONE      = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    M_CLEAR = 2'd0,
    M_CHECK = 2'd1,
    M_SET   = 2'd2
  } mode_t;

  state_t state;
  mode_t  mode;

  logic [BS_W-1:0]    blk_bytes;
  logic [COUNT_W-1:0] blocks_in_use;

  action_t            act_q;
  logic [IDX_W-1:0]   start_q;
  logic [SIZE_W-1:0]  old_q;
  logic [SIZE_W-1:0]  new_q;
  status_t            res_status;
  logic [BLK_W-1:0]   res_idx;

  // divider
  logic [DIVD_W-1:0]  dq;
  logic [BS_W-1:0]    rem;
  logic [STEP_W-1:0]  step;
  logic               div_sel;
  logic [DIVD_W-1:0]  nb_old;
  logic [DIVD_W-1:0]  nb_new;

  // word walk
  logic [WADDR_W-1:0] wptr;
  logic [WADDR_W-1:0] wlast;
  logic [BLK_W-1:0]   rlo;
  logic [CNT_W-1:0]   rhi;

  // map memory
  word_t              mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] mem_vld;
  word_t              rd_data;
  logic               rd_vld;
  logic               mem_we;
  word_t              mem_wdata;

  logic [BS_W-1:0]    bs_eff;
  logic [CNT_W-1:0]   cnt_eff;
  logic [CNT_W-1:0]   cnt_m1;
  logic [WADDR_W-1:0] alast;
  logic [BS_W:0]      shifted;
  logic               ge;
  logic [BS_W-1:0]    rem_next;
  logic [DIVD_W-1:0]  dq_next;
  logic [DIVD_W-1:0]  dvd_old;
  logic [DIVD_W-1:0]  dvd_new;

  logic [SUM_W-1:0]   base;
  logic [SUM_W-1:0]   s_old;
  logic [SUM_W-1:0]   s_new;
  logic [SUM_W-1:0]   lo_sel;
  logic [SUM_W-1:0]   hi_sel;
  mode_t              mode_sel;
  logic               skip;
  logic               compact;
  logic [CNT_W-1:0]   hi_clip;
  logic [CNT_W-1:0]   hi_clip_m1;
  logic               empty;

  word_t              rd_word;
  word_t              lo_mask;
  word_t              hi_mask;
  word_t              rmask;
  logic [CNT_W-1:0]   rhi_m1;
  word_t              amask;
  word_t              free;
  logic [BIT_W-1:0]   fbit;
  logic               out_load;

  assign in_stall = (state != S_IDLE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_bytes     <= BS_W'(64);
      blocks_in_use <= COUNT_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLK_BYTES:     blk_bytes     <= cfg_data[BS_W-1:0];
        CFG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign bs_eff  = (blk_bytes == '0) ? BS_W'(1) : blk_bytes;
  assign cnt_eff = (32'(blocks_in_use) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                     : CNT_W'(blocks_in_use);
  assign cnt_m1  = cnt_eff - CNT_W'(1);
  assign alast   = cnt_m1[BLK_W-1:BIT_W];

  // Restoring divider, one quotient bit per cycle
  assign shifted  = {rem, dq[DIVD_W-1]};
  assign ge       = (shifted >= {1'b0, bs_eff});
  assign rem_next = ge ? BS_W'(shifted - {1'b0, bs_eff}) : shifted[BS_W-1:0];
  assign dq_next  = {dq[DIVD_W-2:0], ge};
  assign dvd_old  = DIVD_W'(old_size) + DIVD_W'(bs_eff) - DIVD_W'(1);
  assign dvd_new  = DIVD_W'(new_q) + DIVD_W'(bs_eff) - DIVD_W'(1);

  // Extent bounds from the block counts
  assign base  = SUM_W'(start_q);
  assign s_old = base + SUM_W'(nb_old);
  assign s_new = base + SUM_W'(nb_new);

  always_comb begin
    lo_sel   = base;
    hi_sel   = s_old;
    mode_sel = M_CLEAR;
    skip     = 1'b0;
    compact  = 1'b0;
    if (act_q == ACT_RESIZE) begin
      priority if (new_q < old_q) begin
        lo_sel = s_new;
        hi_sel = s_old;
      end else if (new_q > old_q && nb_new > nb_old) begin
        lo_sel   = s_old;
        hi_sel   = s_new;
        mode_sel = M_CHECK;
        compact  = (s_new > SUM_W'(cnt_eff));
      end else begin
        skip = 1'b1;
      end
    end
  end

  assign hi_clip    = (hi_sel > SUM_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(hi_sel);
  assign hi_clip_m1 = hi_clip - CNT_W'(1);
  assign empty      = (lo_sel >= SUM_W'(hi_clip));

  // Bit masks for the current word
  assign rd_word = rd_vld ? rd_data : '0;
  assign rhi_m1  = rhi - CNT_W'(1);
  assign lo_mask = (wptr == rlo[BLK_W-1:BIT_W]) ? ('1 << rlo[BIT_W-1:0]) : '1;
  assign hi_mask = (wptr == wlast) ? ('1 >> (BIT_W'(WORD_W - 1) - rhi_m1[BIT_W-1:0])) : '1;
  assign rmask   = lo_mask & hi_mask;
  assign amask   = (wptr == alast) ? ('1 >> (BIT_W'(WORD_W - 1) - cnt_m1[BIT_W-1:0])) : '1;
  assign free    = ~rd_word & amask;

  always_comb begin
    fbit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free[i]) begin
        fbit = BIT_W'(i);
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rd_word;
    if (state == S_ALLOC_CHK && free != '0) begin
      mem_we    = 1'b1;
      mem_wdata = rd_word | (word_t'(1) << fbit);
    end else if (state == S_RNG_WR && mode == M_CLEAR) begin
      mem_we    = 1'b1;
      mem_wdata = rd_word & ~rmask;
    end else if (state == S_RNG_WR && mode == M_SET) begin
      mem_we    = 1'b1;
      mem_wdata = rd_word | rmask;
    end
  end

  // Map memory; a word never written reads as all free
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wptr] <= mem_wdata;
    end
    rd_data <= mem[wptr];
    rd_vld  <= mem_vld[wptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
    end else if (mem_we) begin
      mem_vld[wptr] <= 1'b1;
    end
  end

  // Request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act_q      <= action;
            start_q    <= start_block;
            old_q      <= old_size;
            new_q      <= new_size;
            res_status <= (action == ACT_ALLOC && cnt_eff == '0) ? ST_NONE_FREE : ST_DONE;
            res_idx    <= '0;
            wptr       <= '0;
            dq         <= dvd_old;
            rem        <= '0;
            step       <= '0;
            div_sel    <= 1'b0;
            priority if (action == ACT_ALLOC) begin
              if (cnt_eff == '0) begin
                state <= S_DONE;
              end else begin
                state <= S_ALLOC_RD;
              end
            end else if (action == ACT_RELEASE || action == ACT_RESIZE) begin
              state <= S_DIV;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_ALLOC_RD: state <= S_ALLOC_CHK;
        S_ALLOC_CHK: begin
          priority if (free != '0) begin
            res_idx <= {wptr, fbit};
            state   <= S_DONE;
          end else if (wptr == alast) begin
            res_status <= ST_NONE_FREE;
            state      <= S_DONE;
          end else begin
            wptr  <= wptr + WADDR_W'(1);
            state <= S_ALLOC_RD;
          end
        end
        S_DIV: begin
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            step <= '0;
            if (!div_sel) begin
              nb_old <= dq_next;
              if (act_q == ACT_RESIZE) begin
                dq      <= dvd_new;
                rem     <= '0;
                div_sel <= 1'b1;
              end else begin
                state <= S_SETUP;
              end
            end else begin
              nb_new <= dq_next;
              state  <= S_SETUP;
            end
          end else begin
            dq   <= dq_next;
            rem  <= rem_next;
            step <= step + STEP_W'(1);
          end
        end
        S_SETUP: begin
          priority if (skip) begin
            state <= S_DONE;
          end else if (compact) begin
            res_status <= ST_COMPACT;
            state      <= S_DONE;
          end else if (empty) begin
            state <= S_DONE;
          end else begin
            rlo   <= lo_sel[BLK_W-1:0];
            rhi   <= hi_clip;
            wptr  <= lo_sel[BLK_W-1:BIT_W];
            wlast <= hi_clip_m1[BLK_W-1:BIT_W];
            mode  <= mode_sel;
            state <= S_RNG_RD;
          end
        end
        S_RNG_RD: state <= S_RNG_WR;
        S_RNG_WR: begin
          if (mode == M_CHECK) begin
            priority if ((rd_word & rmask) != '0) begin
              res_status <= ST_COMPACT;
              state      <= S_DONE;
            end else if (wptr == wlast) begin
              // tail is free: rewind and mark it
              mode  <= M_SET;
              wptr  <= rlo[BLK_W-1:BIT_W];
              state <= S_RNG_RD;
            end else begin
              wptr  <= wptr + WADDR_W'(1);
              state <= S_RNG_RD;
            end
          end else if (wptr == wlast) begin
            state <= S_DONE;
          end else begin
            wptr  <= wptr + WADDR_W'(1);
            state <= S_RNG_RD;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: load when empty or being drained
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= res_status;
      block_index <= IDX_W'(res_idx);
    end
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("output beat raised without a finished request");

  a_alloc_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && act_q == ACT_ALLOC && res_status == ST_DONE)
      |-> (CNT_W'(res_idx) < cnt_eff))
    else $error("allocated block beyond the managed count");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RNG_RD) |-> (wptr <= wlast))
    else $error("word walk passed the last word of the extent");

endmodule
